// ----- rtl/gan_pkg.sv -----
// ----------------------------------------------------------------------------
// gan_pkg
// Shared constants and codes for the gamepad axis normaliser.
// ----------------------------------------------------------------------------
package gan_pkg;

  localparam int RAW_WIDTH_DEF     = 16;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int LEVEL_WIDTH       = 15;  // deadzone and threshold
  localparam int CFG_DATA_WIDTH    = 32;
  localparam int CFG_ADDR_WIDTH    = 5;

  typedef enum logic [1:0] {
    KIND_STICK    = 2'd0,
    KIND_TRIGGER  = 2'd1,
    KIND_DPAD_NEG = 2'd2,
    KIND_DPAD_POS = 2'd3
  } axis_kind_t;

  typedef enum logic [2:0] {
    REG_AXIS_KIND  = 3'd0,
    REG_CENTER     = 3'd1,
    REG_RANGE_LOW  = 3'd2,
    REG_RANGE_HIGH = 3'd3,
    REG_INVERT     = 3'd4,
    REG_DEADZONE   = 3'd5,
    REG_THRESHOLD  = 3'd6
  } reg_index_t;

endpackage

// ----- rtl/gamepad_axis_normalizer.sv -----
// ----------------------------------------------------------------------------
// gamepad_axis_normalizer
// Throughput: one word per cycle while out_ready does not stall the output; the
// restoring divider resolves one quotient bit per pipeline stage.
// Reset clears every valid bit and loads the registers with their reset values.
// Maps a raw signed axis sample to a Q2.14 value and a direction flag.
// ----------------------------------------------------------------------------
module gamepad_axis_normalizer
  import gan_pkg::*;
#(
  parameter int RAW_WIDTH     = RAW_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0]         paddr,
  input  logic [CFG_DATA_WIDTH-1:0]         pwdata,
  output logic [CFG_DATA_WIDTH-1:0]         prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [RAW_WIDTH-1:0]       raw_axis,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [FRACTION_BITS+1:0]   scaled_value,
  output logic                              direction_active
);

  localparam int RW = RAW_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int DW = RW + 1;
  localparam int OW = F + 2;
  localparam int NS = F + 2;
  localparam int CW = (F + 1 > LEVEL_WIDTH) ? F + 1 : LEVEL_WIDTH;
  localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

  // registers
  axis_kind_t              axis_kind;
  logic signed [RW-1:0]    center;
  logic signed [RW-1:0]    range_low;
  logic signed [RW-1:0]    range_high;
  logic                    invert;
  logic [LEVEL_WIDTH-1:0]  deadzone;
  logic [LEVEL_WIDTH-1:0]  threshold;

  logic       cfg_write;
  reg_index_t cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_kind  <= KIND_STICK;
      center     <= '0;
      range_low  <= {1'b1, {(RW-1){1'b0}}};
      range_high <= {1'b0, {(RW-1){1'b1}}};
      invert     <= 1'b0;
      deadzone   <= '0;
      threshold  <= LEVEL_WIDTH'(8192);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AXIS_KIND:  axis_kind  <= axis_kind_t'(pwdata[1:0]);
        REG_CENTER:     center     <= pwdata[RW-1:0];
        REG_RANGE_LOW:  range_low  <= pwdata[RW-1:0];
        REG_RANGE_HIGH: range_high <= pwdata[RW-1:0];
        REG_INVERT:     invert     <= pwdata[0];
        REG_DEADZONE:   deadzone   <= pwdata[LEVEL_WIDTH-1:0];
        REG_THRESHOLD:  threshold  <= pwdata[LEVEL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_AXIS_KIND:  prdata = CFG_DATA_WIDTH'(axis_kind);
      REG_CENTER:     prdata = CFG_DATA_WIDTH'(center);
      REG_RANGE_LOW:  prdata = CFG_DATA_WIDTH'(range_low);
      REG_RANGE_HIGH: prdata = CFG_DATA_WIDTH'(range_high);
      REG_INVERT:     prdata = CFG_DATA_WIDTH'(invert);
      REG_DEADZONE:   prdata = CFG_DATA_WIDTH'(deadzone);
      REG_THRESHOLD:  prdata = CFG_DATA_WIDTH'(threshold);
      default:        prdata = '0;
    endcase
  end

  // pipeline advances as one unit
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  logic          st_valid [0:NS-1];
  logic          st_neg   [0:NS-1];
  logic          st_zero  [0:NS-1];
  logic          st_sat   [0:NS-1];
  logic [DW-1:0] st_rem   [0:NS-1];
  logic [DW-1:0] st_den   [0:NS-1];
  logic [F:0]    st_quo   [0:NS-1];

  // front stage: numerator and divisor per kind
  logic signed [DW-1:0] raw_x, c_x, lo_x, hi_x;
  logic signed [DW-1:0] num_s, den_s, trg_num, trg_den;
  logic                 zero_s;

  assign raw_x = {raw_axis[RW-1], raw_axis};
  assign c_x   = {center[RW-1], center};
  assign lo_x  = {range_low[RW-1], range_low};
  assign hi_x  = {range_high[RW-1], range_high};

  always_comb begin
    trg_num = raw_x - lo_x;
    trg_den = hi_x - lo_x;
    unique case (axis_kind)
      KIND_STICK: begin
        num_s  = raw_x - c_x;
        den_s  = (raw_x < c_x) ? (c_x - lo_x) : (hi_x - c_x);
        zero_s = den_s[DW-1] || (den_s == '0);
      end
      KIND_TRIGGER: begin
        num_s  = trg_den[DW-1] ? -trg_num : trg_num;
        den_s  = trg_den[DW-1] ? -trg_den : trg_den;
        zero_s = (trg_den == '0);
      end
      default: begin
        num_s  = raw_x;
        den_s  = raw_axis[RW-1] ? DW'(1) <<< (RW-1) : (DW'(1) <<< (RW-1)) - DW'(1);
        zero_s = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (advance) begin
      st_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_neg[0]  <= num_s[DW-1];
      st_zero[0] <= zero_s;
      st_sat[0]  <= 1'b0;
      st_rem[0]  <= num_s[DW-1] ? DW'(-num_s) : DW'(num_s);
      st_den[0]  <= DW'(den_s);
      st_quo[0]  <= '0;
    end
  end

  // one quotient bit per stage; the first also flags a quotient of two or more
  for (genvar k = 1; k < NS; k++) begin : g_div
    logic [DW:0] r_in, d_x, r_sub;
    logic        q_bit, sat_k;

    if (k == 1) begin : g_first
      assign r_in  = {1'b0, st_rem[k-1]};
      assign sat_k = ({1'b0, st_rem[k-1]} >= {st_den[k-1], 1'b0});
    end else begin : g_rest
      assign r_in  = {st_rem[k-1], 1'b0};
      assign sat_k = st_sat[k-1];
    end

    assign d_x   = {1'b0, st_den[k-1]};
    assign q_bit = (r_in >= d_x);
    assign r_sub = q_bit ? (r_in - d_x) : r_in;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (advance) begin
        st_valid[k] <= st_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st_neg[k]  <= st_neg[k-1];
        st_zero[k] <= st_zero[k-1];
        st_sat[k]  <= sat_k;
        st_rem[k]  <= r_sub[DW-1:0];
        st_den[k]  <= st_den[k-1];
        st_quo[k]  <= {st_quo[k-1][F-1:0], q_bit};
      end
    end
  end

  // clamp, invert, deadzone and threshold
  logic [F:0]           mag_c;
  logic [CW-1:0]        mag_x, dz_x, th_x;
  logic signed [OW-1:0] pos_v, neg_v, val_next;
  logic                 active_next, neg_l, zero_l, at_level;

  assign neg_l    = st_neg[NS-1];
  assign zero_l   = st_zero[NS-1];
  assign mag_c    = (st_sat[NS-1] || st_quo[NS-1] > ONE_Q) ? ONE_Q : st_quo[NS-1];
  assign mag_x    = CW'(mag_c);
  assign dz_x     = CW'(deadzone);
  assign th_x     = CW'(threshold);
  assign pos_v    = OW'(mag_c);
  assign neg_v    = -pos_v;
  assign at_level = (mag_x >= th_x);

  always_comb begin
    active_next = 1'b0;
    unique case (axis_kind)
      KIND_STICK: begin
        if (zero_l || mag_x < dz_x) val_next = '0;
        else                        val_next = (neg_l ^ invert) ? neg_v : pos_v;
      end
      KIND_TRIGGER: begin
        val_next = (zero_l || neg_l) ? '0 : pos_v;
      end
      KIND_DPAD_NEG: begin
        val_next    = neg_l ? neg_v : pos_v;
        active_next = (neg_l || mag_c == '0) && at_level;
      end
      default: begin
        val_next    = neg_l ? neg_v : pos_v;
        active_next = (!neg_l || mag_c == '0) && at_level;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= st_valid[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      scaled_value     <= val_next;
      direction_active <= active_next;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the gamepad axis normaliser word by word against an in-bench
// predictor. Directed tests cover each axis kind and its corner cases, then
// random calibrations and samples run under varying source and sink pacing.
// ----------------------------------------------------------------------------
module tb_top;
  import gan_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     OUT_WIDTH    = FRACTION_BITS_DEF + 2;
  localparam longint ONE_Q        = longint'(1) << FRACTION_BITS_DEF;
  localparam longint RAW_HALF     = longint'(1) << (RAW_WIDTH_DEF - 1);
  localparam int     REG_STRIDE   = 4;
  localparam int     NUM_REGS     = 7;
  localparam int     SETUP_EVERY  = 15;
  localparam int     DRAIN_CYCLES = 2 * (FRACTION_BITS_DEF + 3) + 8;
  localparam int     IDLE_LIMIT   = 5000;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] scaled;
    logic                        active;
  } axis_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             psel    = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite  = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0]        paddr   = '0;
  logic [CFG_DATA_WIDTH-1:0]        pwdata  = '0;
  logic [CFG_DATA_WIDTH-1:0]        prdata;
  logic                             pready;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  logic signed [RAW_WIDTH_DEF-1:0]  raw_axis  = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [OUT_WIDTH-1:0]      scaled_value;
  logic                             direction_active;

  // shadow of the calibration registers
  axis_kind_t                      cfg_kind       = KIND_STICK;
  logic signed [RAW_WIDTH_DEF-1:0] cfg_center     = 16'sd0;
  logic signed [RAW_WIDTH_DEF-1:0] cfg_range_low  = -16'sd32768;
  logic signed [RAW_WIDTH_DEF-1:0] cfg_range_high = 16'sd32767;
  logic                            cfg_invert     = 1'b0;
  logic [LEVEL_WIDTH-1:0]          cfg_deadzone   = '0;
  logic [LEVEL_WIDTH-1:0]          cfg_threshold  = 15'd8192;

  axis_result_t predicted_axis_q[$];
  int unsigned  mismatch_count = 0;
  int unsigned  tx_idle_pct    = 0;
  int unsigned  rx_stall_pct   = 0;

  gamepad_axis_normalizer i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_axis         (raw_axis),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .scaled_value     (scaled_value),
    .direction_active (direction_active)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_q(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic axis_result_t predict_axis(logic signed [RAW_WIDTH_DEF-1:0] raw);
    longint       r, c, lo, hi, den, num, v;
    axis_result_t res;
    r  = raw;
    c  = cfg_center;
    lo = cfg_range_low;
    hi = cfg_range_high;
    v  = 0;
    res.active = 1'b0;
    case (cfg_kind)
      KIND_STICK: begin
        den = (r < c) ? c - lo : hi - c;
        if (den > 0) begin
          v = clamp_q((r - c) * ONE_Q / den, -ONE_Q, ONE_Q);
          if (cfg_invert) v = -v;
          if (((v < 0) ? -v : v) < longint'(cfg_deadzone)) v = 0;
        end
      end
      KIND_TRIGGER: begin
        den = hi - lo;
        num = r - lo;
        if (den != 0) begin
          if (den < 0) begin
            den = -den;
            num = -num;
          end
          v = clamp_q(num * ONE_Q / den, 0, ONE_Q);
        end
      end
      default: begin
        den = (r < 0) ? RAW_HALF : RAW_HALF - 1;
        v = clamp_q(r * ONE_Q / den, -ONE_Q, ONE_Q);
        if (cfg_kind == KIND_DPAD_NEG) res.active = (v <= -longint'(cfg_threshold));
        else res.active = (v >= longint'(cfg_threshold));
      end
    endcase
    res.scaled = v[OUT_WIDTH-1:0];
    return res;
  endfunction

  // output check, then log the accepted sample
  always @(posedge clk) begin : result_check
    axis_result_t exp_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (predicted_axis_q.size() == 0) begin
          $error("output word with none pending: scaled_value %0d", scaled_value);
          mismatch_count++;
        end else begin
          exp_r = predicted_axis_q.pop_front();
          if (scaled_value !== exp_r.scaled) begin
            $error("scaled_value: expected %0d, actual %0d", exp_r.scaled, scaled_value);
            mismatch_count++;
          end
          if (direction_active !== exp_r.active) begin
            $error("direction_active: expected %0d, actual %0d", exp_r.active,
                   direction_active);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) predicted_axis_q.push_back(predict_axis(raw_axis));
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic drive_sample(logic signed [RAW_WIDTH_DEF-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_axis <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_axis_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [CFG_DATA_WIDTH-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_WIDTH'(idx * REG_STRIDE);
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_AXIS_KIND:  cfg_kind       = axis_kind_t'(d[1:0]);
      REG_CENTER:     cfg_center     = d[RAW_WIDTH_DEF-1:0];
      REG_RANGE_LOW:  cfg_range_low  = d[RAW_WIDTH_DEF-1:0];
      REG_RANGE_HIGH: cfg_range_high = d[RAW_WIDTH_DEF-1:0];
      REG_INVERT:     cfg_invert     = d[0];
      REG_DEADZONE:   cfg_deadzone   = d[LEVEL_WIDTH-1:0];
      REG_THRESHOLD:  cfg_threshold  = d[LEVEL_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // upper bits carry junk; the block must mask them
  task automatic set_axis(axis_kind_t kind, int c, int lo, int hi, bit inv, int dz, int thr);
    wait_drained();
    write_reg(REG_AXIS_KIND,  {30'($urandom()), kind});
    write_reg(REG_CENTER,     {16'($urandom()), 16'(c)});
    write_reg(REG_RANGE_LOW,  {16'($urandom()), 16'(lo)});
    write_reg(REG_RANGE_HIGH, {16'($urandom()), 16'(hi)});
    write_reg(REG_INVERT,     {31'($urandom()), inv});
    write_reg(REG_DEADZONE,   {17'($urandom()), 15'(dz)});
    write_reg(REG_THRESHOLD,  {17'($urandom()), 15'(thr)});
  endtask

  task automatic test_reset_defaults();
    drive_sample(-16'sd32768);
    drive_sample(-16'sd1);
    drive_sample(16'sd0);
    drive_sample(16'sd1);
    drive_sample(16'sd32767);
  endtask

  task automatic test_stick();
    set_axis(KIND_STICK, 1000, -20000, 30000, 1'b0, 2000, 8192);
    drive_sample(-16'sd32768);
    drive_sample(-16'sd19000);
    drive_sample(16'sd1000);
    drive_sample(16'sd1500);
    drive_sample(16'sd32767);
    set_axis(KIND_STICK, 1000, -20000, 30000, 1'b1, 0, 8192);
    drive_sample(-16'sd10000);
    drive_sample(16'sd20000);
    // lower span zero, upper span negative
    set_axis(KIND_STICK, -20000, -20000, -30000, 1'b1, 100, 8192);
    drive_sample(-16'sd32768);
    drive_sample(16'sd0);
    // deadzone beyond full scale
    set_axis(KIND_STICK, 0, -32768, 32767, 1'b0, 32767, 8192);
    drive_sample(16'sd32767);
  endtask

  task automatic test_trigger();
    set_axis(KIND_TRIGGER, 0, -32768, 32767, 1'b0, 0, 8192);
    drive_sample(-16'sd32768);
    drive_sample(16'sd32767);
    set_axis(KIND_TRIGGER, 0, 20000, -20000, 1'b0, 0, 8192);
    drive_sample(16'sd0);
    drive_sample(16'sd32767);
    set_axis(KIND_TRIGGER, 0, 5, 5, 1'b0, 0, 8192);
    drive_sample(16'sd100);
  endtask

  task automatic test_dpad();
    set_axis(KIND_DPAD_NEG, 0, -32768, 32767, 1'b0, 0, 0);
    drive_sample(16'sd0);
    drive_sample(16'sd1);
    set_axis(KIND_DPAD_POS, 0, -32768, 32767, 1'b0, 0, 0);
    drive_sample(16'sd0);
    drive_sample(-16'sd1);
    set_axis(KIND_DPAD_NEG, 0, -32768, 32767, 1'b0, 0, 16384);
    drive_sample(-16'sd32768);
    set_axis(KIND_DPAD_POS, 0, -32768, 32767, 1'b0, 0, 16384);
    drive_sample(16'sd32767);
    set_axis(KIND_DPAD_POS, 0, -32768, 32767, 1'b0, 0, 16385);
    drive_sample(16'sd32767);
  endtask

  task automatic test_unmapped_write();
    wait_drained();
    write_reg(NUM_REGS, $urandom());
    drive_sample(16'sd32767);
  endtask

  task automatic test_random_traffic(int unsigned tx_pct, int unsigned rx_pct, int n_items);
    axis_kind_t kind;
    int         c, lo, hi, dz, thr, tmp;
    bit         inv;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % SETUP_EVERY == 0) begin
        kind = axis_kind_t'($urandom_range(0, 3));
        inv  = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
          0: begin
            c  = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 2000)) - 1000;
            lo = -32768;
            hi = 32767;
          end
          1: begin
            c  = $urandom();
            lo = $urandom();
            hi = $urandom();
          end
          default: begin
            c  = int'($urandom_range(0, 8000)) - 4000;
            lo = c - int'($urandom_range(500, 28000));
            hi = c + int'($urandom_range(500, 28000));
            if (lo < -32768) lo = -32768;
            if (hi > 32767) hi = 32767;
          end
        endcase
        case ($urandom_range(0, 5))
          0: dz = 0;
          1: dz = 16384;
          2: dz = $urandom_range(16385, 32767);
          default: dz = $urandom_range(1, 5000);
        endcase
        case ($urandom_range(0, 5))
          0: thr = 0;
          1: thr = 16384;
          2: thr = $urandom_range(16385, 32767);
          default: thr = $urandom_range(1, 16383);
        endcase
        set_axis(kind, c, lo, hi, inv, dz, thr);
      end
      case ($urandom_range(0, 7))
        0: case ($urandom_range(0, 2))
             0: tmp = -32768;
             1: tmp = 32767;
             default: tmp = 0;
           endcase
        1: tmp = int'(cfg_center) + int'($urandom_range(0, 64)) - 32;
        2: tmp = int'(cfg_range_low) + int'($urandom_range(0, 64)) - 32;
        3: tmp = int'(cfg_range_high) + int'($urandom_range(0, 64)) - 32;
        default: tmp = $urandom();
      endcase
      drive_sample(16'(tmp));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_stick();
    test_trigger();
    test_dpad();
    test_unmapped_write();
    test_random_traffic(0, 0, 120);
    test_random_traffic(88, 0, 120);
    test_random_traffic(0, 88, 120);
    test_random_traffic(8, 8, 120);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_axis_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
